### sv/mlcc_pkg.sv
// Shared constants, codes and controller/datapath link types for min-leftover coin change.
package mlcc_pkg;

  localparam int TABLE_SIZE_DEF = 4096;
  localparam int NUM_COINS_DEF  = 8;

  localparam int NREGS    = 8;
  localparam int IDX_W    = 3;
  localparam int COIN_W   = 12;
  localparam int TARGET_W = 16;
  localparam int OUT_W    = 12;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE,
    ST_COMPARE,
    ST_WRITE,
    ST_RES_READ,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_target;
    logic clear_best;
    logic issue_coin;
    logic cmp_coin;
    logic write_entry;
    logic read_result;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic oor;
    logic no_coin;
    logic need_fill;
    logic last_coin;
    logic out_busy;
  } dp_sts_t;

endpackage

### sv/mlcc_if.sv
// Valid/ready channel interfaces for targets and results.
interface mlcc_query_if;
  logic                          valid;
  logic                          ready;
  logic [mlcc_pkg::TARGET_W-1:0] target_value;

  modport source (output valid, output target_value, input ready);
  modport sink (input valid, input target_value, output ready);
endinterface

interface mlcc_answer_if;
  logic                       valid;
  logic                       ready;
  logic [mlcc_pkg::OUT_W-1:0] leftover;
  logic [mlcc_pkg::OUT_W-1:0] coin_count;
  logic                       exact;
  logic                       out_of_range;

  modport source (output valid, output leftover, output coin_count, output exact,
                  output out_of_range, input ready);
  modport sink (input valid, input leftover, input coin_count, input exact,
                input out_of_range, output ready);
endinterface

### sv/mlcc_ctrl.sv
// Sequencer that fills the memo table and issues lookups and result loads.
module mlcc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               query_valid,
  output logic               query_ready,
  input  mlcc_pkg::dp_sts_t  sts,
  output mlcc_pkg::ctl_cmd_t cmd
);

  mlcc_pkg::state_t state;
  mlcc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mlcc_pkg::ST_IDLE: begin
        if (query_valid) begin
          state_next = mlcc_pkg::ST_CHECK;
        end
      end
      mlcc_pkg::ST_CHECK: begin
        if (sts.oor || sts.no_coin) begin
          state_next = mlcc_pkg::ST_FINISH;
        end else if (sts.need_fill) begin
          state_next = mlcc_pkg::ST_ISSUE;
        end else begin
          state_next = mlcc_pkg::ST_RES_READ;
        end
      end
      mlcc_pkg::ST_ISSUE: begin
        state_next = mlcc_pkg::ST_COMPARE;
      end
      mlcc_pkg::ST_COMPARE: begin
        state_next = sts.last_coin ? mlcc_pkg::ST_WRITE : mlcc_pkg::ST_ISSUE;
      end
      mlcc_pkg::ST_WRITE: begin
        state_next = mlcc_pkg::ST_CHECK;
      end
      mlcc_pkg::ST_RES_READ: begin
        state_next = mlcc_pkg::ST_FINISH;
      end
      mlcc_pkg::ST_FINISH: begin
        if (!sts.out_busy) begin
          state_next = mlcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mlcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    query_ready = 1'b0;
    unique case (state)
      mlcc_pkg::ST_IDLE: begin
        query_ready     = 1'b1;
        cmd.load_target = query_valid;
      end
      mlcc_pkg::ST_CHECK: begin
        cmd.clear_best = 1'b1;
      end
      mlcc_pkg::ST_ISSUE: begin
        cmd.issue_coin = 1'b1;
      end
      mlcc_pkg::ST_COMPARE: begin
        cmd.cmp_coin = 1'b1;
      end
      mlcc_pkg::ST_WRITE: begin
        cmd.write_entry = 1'b1;
      end
      mlcc_pkg::ST_RES_READ: begin
        cmd.read_result = 1'b1;
      end
      mlcc_pkg::ST_FINISH: begin
        cmd.load_out = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### sv/mlcc_dpath.sv
// Coin registers, memo table, best-candidate compare and result register.
module mlcc_dpath #(
  parameter int TABLE_SIZE = mlcc_pkg::TABLE_SIZE_DEF,
  parameter int NUM_COINS  = mlcc_pkg::NUM_COINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mlcc_pkg::ctl_cmd_t            cmd,
  output mlcc_pkg::dp_sts_t             sts,
  input  logic [mlcc_pkg::TARGET_W-1:0] target_value,
  input  logic                          cfg_wr,
  input  logic [mlcc_pkg::IDX_W-1:0]    cfg_idx,
  input  logic [mlcc_pkg::DATA_W-1:0]   cfg_data,
  output logic [mlcc_pkg::DATA_W-1:0]   cfg_rdata,
  output logic                          ans_valid,
  input  logic                          ans_ready,
  output logic [mlcc_pkg::OUT_W-1:0]    leftover,
  output logic [mlcc_pkg::OUT_W-1:0]    coin_count,
  output logic                          exact,
  output logic                          out_of_range
);

  localparam int AW    = $clog2(TABLE_SIZE);
  localparam int CNT_W = AW + 1;
  localparam int WW    = (AW > mlcc_pkg::COIN_W) ? AW : mlcc_pkg::COIN_W;
  localparam int EW    = 1 + 2 * AW;

  logic [mlcc_pkg::COIN_W-1:0]   coin [mlcc_pkg::NREGS];
  logic [CNT_W-1:0]              filled;
  logic [mlcc_pkg::TARGET_W-1:0] tgt;
  logic [mlcc_pkg::IDX_W-1:0]    coin_idx;
  logic [EW-1:0]                 mem [TABLE_SIZE];
  logic [EW-1:0]                 rd_q;
  logic                          elig_q;
  logic                          found;
  logic                          b_exact;
  logic [AW-1:0]                 b_left;
  logic [AW-1:0]                 b_count;

  logic                          oor;
  logic                          any_coin;
  logic [AW-1:0]                 t_idx;
  logic [AW-1:0]                 v;
  logic                          need_fill;
  logic [mlcc_pkg::COIN_W-1:0]   coin_sel;
  logic                          eligible;
  logic [WW-1:0]                 diff;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic                          rd_exact;
  logic [AW-1:0]                 rd_left;
  logic [AW-1:0]                 rd_count;
  logic                          better;
  logic [EW-1:0]                 entry;
  logic [WW-1:0]                 wide_left;
  logic [WW-1:0]                 wide_count;
  logic                          out_busy;

  assign oor       = {1'b0, tgt} >= (mlcc_pkg::TARGET_W + 1)'(TABLE_SIZE);
  assign t_idx     = tgt[AW-1:0];
  assign v         = filled[AW-1:0];
  assign need_fill = filled <= {1'b0, t_idx};
  assign coin_sel  = coin[coin_idx];
  assign eligible  = (coin_sel != '0) && (WW'(coin_sel) <= WW'(v));
  assign diff      = WW'(v) - WW'(coin_sel);
  assign rd_en     = cmd.issue_coin || cmd.read_result;
  assign rd_addr   = cmd.issue_coin ? diff[AW-1:0] : t_idx;
  assign rd_exact  = rd_q[EW-1];
  assign rd_left   = rd_q[2*AW-1:AW];
  assign rd_count  = rd_q[AW-1:0];
  assign out_busy  = ans_valid && !ans_ready;

  always_comb begin
    any_coin = 1'b0;
    for (int i = 0; i < NUM_COINS; i++) begin
      if (coin[i] != '0) begin
        any_coin = 1'b1;
      end
    end
  end

  always_comb begin
    if (!found) begin
      better = 1'b1;
    end else if (rd_exact != b_exact) begin
      better = rd_exact;
    end else if (rd_left != b_left) begin
      better = rd_left < b_left;
    end else begin
      better = rd_count < b_count;
    end
  end

  always_comb begin
    if (v == '0) begin
      entry = {1'b1, AW'(0), AW'(0)};
    end else if (!found) begin
      entry = {1'b0, v, AW'(0)};
    end else begin
      entry = {b_exact, b_left, b_count + AW'(1)};
    end
  end

  always_comb begin
    sts.oor       = oor;
    sts.no_coin   = !any_coin;
    sts.need_fill = need_fill;
    sts.last_coin = coin_idx == mlcc_pkg::IDX_W'(NUM_COINS - 1);
    sts.out_busy  = out_busy;
  end

  assign cfg_rdata = mlcc_pkg::DATA_W'(coin[cfg_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mlcc_pkg::NREGS; i++) begin
        coin[i] <= '0;
      end
      filled <= '0;
    end else if (cfg_wr) begin
      coin[cfg_idx] <= cfg_data[mlcc_pkg::COIN_W-1:0];
      filled        <= '0;
    end else if (cmd.write_entry) begin
      filled <= filled + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_target) begin
      tgt <= target_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coin_idx <= '0;
      found    <= 1'b0;
    end else if (cmd.clear_best) begin
      coin_idx <= '0;
      found    <= 1'b0;
    end else if (cmd.cmp_coin) begin
      coin_idx <= coin_idx + mlcc_pkg::IDX_W'(1);
      if (elig_q && better) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_coin && elig_q && better) begin
      b_exact <= rd_exact;
      b_left  <= rd_left;
      b_count <= rd_count;
    end
    if (cmd.issue_coin) begin
      elig_q <= eligible;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      mem[v] <= entry;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign wide_left  = WW'(rd_left);
  assign wide_count = WW'(rd_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      ans_valid <= 1'b0;
    end else if (cmd.load_out) begin
      ans_valid <= 1'b1;
    end else if (ans_ready) begin
      ans_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (oor) begin
        leftover     <= '0;
        coin_count   <= '0;
        exact        <= 1'b0;
        out_of_range <= 1'b1;
      end else if (!any_coin) begin
        leftover     <= tgt[mlcc_pkg::OUT_W-1:0];
        coin_count   <= '0;
        exact        <= tgt == '0;
        out_of_range <= 1'b0;
      end else begin
        leftover     <= wide_left[mlcc_pkg::OUT_W-1:0];
        coin_count   <= wide_count[mlcc_pkg::OUT_W-1:0];
        exact        <= rd_exact;
        out_of_range <= 1'b0;
      end
    end
  end

  a_write_below_target: assert property (@(posedge clk) disable iff (rst)
    cmd.write_entry |-> need_fill)
    else $error("memo write past the target");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.write_entry && rd_en))
    else $error("memo read and write in one cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= CNT_W'(TABLE_SIZE))
    else $error("fill count beyond table");

  a_oor_fields: assert property (@(posedge clk) disable iff (rst)
    (ans_valid && out_of_range) |-> (leftover == '0 && coin_count == '0 && !exact))
    else $error("out of range result carries data");

  a_found_after_eligible: assert property (@(posedge clk) disable iff (rst)
    (cmd.cmp_coin && elig_q) |=> found)
    else $error("eligible coin left no candidate");

endmodule

### sv/min_leftover_coin_change.sv
// Top level of min-leftover coin change: channels, register port, controller and datapath.
//
//   channel  | dir | handshake      | payload
//   query    | in  | valid/ready    | target_value[15:0]
//   answer   | out | valid/ready    | leftover[11:0], coin_count[11:0], exact, out_of_range
//   apb      | in  | psel/penable   | paddr[4:2] selects coin_value_0..7, pwdata[11:0]
//
// A target already in the memo table goes through the check, result-read and finish
// states. Each missing entry up to the target is filled in turn (one memo read and
// one compare per coin through the single table read port, then a write), so a cold
// target t fills (t + 1 - fill count) entries. A coin write empties the table.
// Reset clears the coin registers, the fill count and the control state.
// A finished result waits in the output register; the next target transfers meanwhile.
module min_leftover_coin_change #(
  parameter int TABLE_SIZE = mlcc_pkg::TABLE_SIZE_DEF,
  parameter int NUM_COINS  = mlcc_pkg::NUM_COINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  mlcc_query_if.sink                    query,
  mlcc_answer_if.source                 answer,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mlcc_pkg::ADDR_W-1:0]   paddr,
  input  logic [mlcc_pkg::DATA_W-1:0]   pwdata,
  output logic [mlcc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  mlcc_pkg::ctl_cmd_t cmd;
  mlcc_pkg::dp_sts_t  sts;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  mlcc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .query_valid (query.valid),
    .query_ready (query.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  mlcc_dpath #(
    .TABLE_SIZE (TABLE_SIZE),
    .NUM_COINS  (NUM_COINS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .target_value (query.target_value),
    .cfg_wr       (cfg_wr),
    .cfg_idx      (paddr[mlcc_pkg::ADDR_W-1:2]),
    .cfg_data     (pwdata),
    .cfg_rdata    (prdata),
    .ans_valid    (answer.valid),
    .ans_ready    (answer.ready),
    .leftover     (answer.leftover),
    .coin_count   (answer.coin_count),
    .exact        (answer.exact),
    .out_of_range (answer.out_of_range)
  );

endmodule

### tb/mlcc_checker.sv
// Answer checker for min-leftover coin change: tracks coin writes, predicts and compares answers.
`timescale 1ns / 1ps
module mlcc_checker
  import mlcc_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int NUM_COINS  = NUM_COINS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  mlcc_query_if             query,
  mlcc_answer_if            answer,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                failures,
  output int                outstanding
);

  typedef struct packed {
    logic [OUT_W-1:0] leftover;
    logic [OUT_W-1:0] coin_count;
    logic             exact;
    logic             out_of_range;
  } answer_t;

  typedef struct {
    logic [TARGET_W-1:0] target;
    answer_t             answer;
  } awaited_t;

  awaited_t          awaited_answers[$];
  logic [COIN_W-1:0] coin_value[NREGS];
  int unsigned       best_rest[TABLE_SIZE];
  int unsigned       best_coins[TABLE_SIZE];
  bit                best_exact[TABLE_SIZE];
  int unsigned       fill_mark;
  int                fail_count = 0;

  assign failures = fail_count;

  task automatic report_mismatch(input string what, input logic [TARGET_W-1:0] target,
                                 input int got, input int want);
    $display("%0t: target %0d: %s got %0d want %0d", $time, target, what, got, want);
    fail_count++;
  endtask

  function automatic void fill_entry(input int unsigned v);
    bit          found;
    bit          better;
    bit          pick_exact;
    int unsigned pick_rest;
    int unsigned pick_coins;
    int unsigned rest;
    found = 1'b0;
    pick_exact = 1'b0;
    pick_rest = 0;
    pick_coins = 0;
    if (v == 0) begin
      best_exact[0] = 1'b1;
      best_rest[0] = 0;
      best_coins[0] = 0;
      return;
    end
    for (int i = 0; i < NUM_COINS && i < NREGS; i++) begin
      if (coin_value[i] == 0 || coin_value[i] > v) continue;
      rest = v - coin_value[i];
      if (!found) begin
        better = 1'b1;
      end else if (best_exact[rest] != pick_exact) begin
        better = best_exact[rest];
      end else if (best_rest[rest] != pick_rest) begin
        better = best_rest[rest] < pick_rest;
      end else begin
        better = best_coins[rest] < pick_coins;
      end
      if (better) begin
        found = 1'b1;
        pick_exact = best_exact[rest];
        pick_rest = best_rest[rest];
        pick_coins = best_coins[rest];
      end
    end
    if (!found) begin
      best_exact[v] = 1'b0;
      best_rest[v] = v;
      best_coins[v] = 0;
    end else begin
      best_exact[v] = pick_exact;
      best_rest[v] = pick_rest;
      best_coins[v] = pick_coins + 1;
    end
  endfunction

  function automatic answer_t predict_answer(input logic [TARGET_W-1:0] target);
    answer_t     a;
    bit          any_coin;
    int unsigned t;
    a = '0;
    any_coin = 1'b0;
    t = target;
    if (t >= TABLE_SIZE) begin
      a.out_of_range = 1'b1;
      return a;
    end
    for (int i = 0; i < NUM_COINS && i < NREGS; i++) begin
      if (coin_value[i] != 0) any_coin = 1'b1;
    end
    if (!any_coin) begin
      a.leftover = OUT_W'(t);
      a.exact = (t == 0);
      return a;
    end
    while (fill_mark <= t) begin
      fill_entry(fill_mark);
      fill_mark++;
    end
    a.leftover = OUT_W'(best_rest[t]);
    a.coin_count = OUT_W'(best_coins[t]);
    a.exact = best_exact[t];
    return a;
  endfunction

  always @(posedge clk) begin
    awaited_t    want;
    int unsigned reg_index;
    if (rst) begin
      awaited_answers.delete();
      fill_mark = 0;
      foreach (coin_value[i]) coin_value[i] = '0;
    end else begin
      if (answer.valid && answer.ready) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch("unexpected answer, leftover", '0, answer.leftover, 0);
        end else begin
          want = awaited_answers.pop_front();
          if (answer.leftover !== want.answer.leftover)
            report_mismatch("leftover", want.target, answer.leftover, want.answer.leftover);
          if (answer.coin_count !== want.answer.coin_count)
            report_mismatch("coin_count", want.target, answer.coin_count,
                            want.answer.coin_count);
          if (answer.exact !== want.answer.exact)
            report_mismatch("exact", want.target, answer.exact, want.answer.exact);
          if (answer.out_of_range !== want.answer.out_of_range)
            report_mismatch("out_of_range", want.target, answer.out_of_range,
                            want.answer.out_of_range);
        end
      end
      if (query.valid && query.ready) begin
        want.target = query.target_value;
        want.answer = predict_answer(query.target_value);
        awaited_answers = {awaited_answers, want};
      end
      if (psel && penable && pwrite && pready) begin
        reg_index = paddr >> 2;
        if (reg_index < NREGS) begin
          coin_value[reg_index] = pwdata[COIN_W-1:0];
          fill_mark = 0;
        end
      end
    end
    outstanding <= awaited_answers.size();
  end

endmodule

### tb/testbench.sv
// Testbench top for min-leftover coin change: clock, reset, targets, coin writes and verdict.
`timescale 1ns / 1ps
module testbench;
  import mlcc_pkg::*;

  localparam int HOLD_OFF_CYCLES   = 400;
  localparam int STALL_LIMIT       = 250000;
  localparam int RANDOM_PHASES     = 8;
  localparam int TARGETS_PER_PHASE = 155;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  int                failures;
  int                outstanding;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                hold_off_requests;
  int                idle_cycles;

  mlcc_query_if  query_ch();
  mlcc_answer_if answer_ch();

  min_leftover_coin_change DUT (
    .clk     (clk),
    .rst     (rst),
    .query   (query_ch),
    .answer  (answer_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mlcc_checker answer_check (
    .clk         (clk),
    .rst         (rst),
    .query       (query_ch),
    .answer      (answer_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // answer side: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    answer_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_seen != hold_off_requests) begin
        hold_seen = hold_off_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        answer_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        answer_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (query_ch.valid && query_ch.ready) || (answer_ch.valid && answer_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 69;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 69;
      end
      default: begin
        send_idle_pct = 9;
        recv_stall_pct = 9;
      end
    endcase
  endtask

  // valid stays high across back-to-back transfers
  task automatic send_target(input logic [TARGET_W-1:0] target);
    while ($urandom_range(99) < send_idle_pct) begin
      query_ch.valid <= 1'b0;
      @(posedge clk);
    end
    query_ch.valid <= 1'b1;
    query_ch.target_value <= target;
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
  endtask

  task automatic drain_answers();
    query_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_coin(input int index, input logic [COIN_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(index * 4);
    pwdata <= ($urandom() & 32'hFFFF_F000) | DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [COIN_W-1:0]   coins[NREGS];
    logic [TARGET_W-1:0] target;
    int                  roll;
    int                  bare_targets[$];
    int                  mixed_targets[$];
    bare_targets = '{0, 1, 2730, 4095, 4096, 65535};
    mixed_targets = '{0, 5, 6, 13, 26, 4094, 4095, 4096, 21845, 43690, 32768};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    query_ch.valid = 1'b0;
    query_ch.target_value = '0;
    hold_off_requests = 0;
    set_idling(0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no active coins after reset
    foreach (bare_targets[i]) send_target(TARGET_W'(bare_targets[i]));
    drain_answers();

    // mixed coins, with gaps and one coin at the top of the range
    coins = '{12'd6, 12'd9, 12'd20, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd0};
    foreach (coins[i]) write_coin(i, coins[i]);
    foreach (mixed_targets[i]) send_target(TARGET_W'(mixed_targets[i]));
    drain_answers();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int i = 0; i < NREGS; i++) begin
        roll = $urandom_range(9);
        if (phase == 2) coins[i] = '0;
        else if (phase == 5) coins[i] = '1;
        else if (roll < 4) coins[i] = '0;
        else if (roll < 7) coins[i] = COIN_W'($urandom_range(40, 1));
        else if (roll < 9) coins[i] = COIN_W'($urandom_range(4094, 41));
        else coins[i] = '1;
      end
      if (phase == 6) coins[NREGS-1] = 12'd1;
      for (int i = 0; i < NREGS; i++) write_coin(i, coins[i]);

      for (int n = 0; n < TARGETS_PER_PHASE; n++) begin
        if (n % 40 == 0) set_idling((phase + n / 40) % 4);
        if (phase == 1 && n == 30) hold_off_requests++;
        roll = $urandom_range(99);
        if (roll < 70) target = TARGET_W'($urandom_range(255));
        else if (roll < 82) target = TARGET_W'($urandom_range(1023));
        else if (roll < 87) target = TARGET_W'($urandom_range(4095));
        else if (roll < 97) target = TARGET_W'($urandom_range(65535, 4096));
        else if (roll == 97) target = '0;
        else if (roll == 98) target = TARGET_W'(4095);
        else target = '1;
        send_target(target);
      end
      drain_answers();
    end

    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
